### design/gqc_pkg.sv
// shared widths, constants and fixed point helpers of the gimbal compensation block
package gqc_pkg;

    // field widths and fixed point format
    localparam int ANGLE_WIDTH  = 16;
    localparam int VALUE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int QF           = 30;
    localparam int QW           = 34;
    localparam int ANG_SHIFT    = QF + 3 - ANGLE_WIDTH;

    // pipeline latencies
    localparam int EULER_LAT = CORDIC_STEPS + 4;
    localparam int MAP_LAT   = 4;
    localparam int DRV_LAT   = 2 * EULER_LAT + MAP_LAT;

    typedef logic signed [QW-1:0]   t_q;
    typedef logic signed [2*QW-1:0] t_qq;

    localparam t_q GAIN_Q    = t_q'(64'sd652032874);
    localparam t_q PI_Q      = t_q'(64'sd3373259426);
    localparam t_q HALF_PI_Q = t_q'(64'sd1686629713);
    localparam t_qq RND_Q    = {{(2*QW-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};

    // q.30 product rounded to nearest, ties upward
    function automatic t_q mulq(input t_q a, input t_q b);
        t_qq p;
        p = a * b;
        p = p + RND_Q;
        return t_q'(p >>> QF);
    endfunction

    // atan(2^-i) in q.30, truncated
    function automatic t_q atan_q(input int i);
        int v;
        case (i)
            0:  v = 843314856;
            1:  v = 497837829;
            2:  v = 263043836;
            3:  v = 133525158;
            4:  v = 67021686;
            5:  v = 33543515;
            6:  v = 16775850;
            7:  v = 8388437;
            8:  v = 4194282;
            9:  v = 2097149;
            10: v = 1048575;
            11: v = 524287;
            12: v = 262143;
            13: v = 131071;
            14: v = 65535;
            15: v = 32767;
            16: v = 16383;
            17: v = 8191;
            18: v = 4095;
            19: v = 2047;
            20: v = 1023;
            21: v = 511;
            22: v = 255;
            23: v = 127;
            24: v = 63;
            25: v = 31;
            26: v = 15;
            27: v = 7;
            28: v = 3;
            29: v = 1;
            default: v = 0;
        endcase
        return t_q'(v);
    endfunction

endpackage

### design/gqc_euler.sv
// euler angles to quaternion: three pipelined half-angle cordics and product stages
module gqc_euler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  gqc_pkg::t_q   i_roll,
    input  gqc_pkg::t_q   i_pitch,
    input  gqc_pkg::t_q   i_yaw,
    output logic          o_valid,
    output gqc_pkg::t_q   o_a,
    output gqc_pkg::t_q   o_b,
    output gqc_pkg::t_q   o_c,
    output gqc_pkg::t_q   o_d
);

    localparam int STEPS = gqc_pkg::CORDIC_STEPS;

    gqc_pkg::t_q r_x [0:2][0:STEPS];
    gqc_pkg::t_q r_y [0:2][0:STEPS];
    gqc_pkg::t_q r_z [0:2][0:STEPS];
    logic        r_neg [0:2][0:STEPS];
    logic        r_v [0:STEPS+3];

    gqc_pkg::t_q w_ang [0:2];
    gqc_pkg::t_q n_half [0:2];
    gqc_pkg::t_q w_s [0:2];
    gqc_pkg::t_q w_c [0:2];

    gqc_pkg::t_q r_cycp, r_sysp, r_sycp, r_cysp, r_sr, r_cr;
    gqc_pkg::t_q r_p0, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;

    assign w_ang[0] = i_roll;
    assign w_ang[1] = i_pitch;
    assign w_ang[2] = i_yaw;

    // half angles and cordic outputs with sign fixup
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_half[k] = w_ang[k] >>> 1;
            w_s[k] = r_neg[k][STEPS] ? -r_y[k][STEPS] : r_y[k][STEPS];
            w_c[k] = r_neg[k][STEPS] ? -r_x[k][STEPS] : r_x[k][STEPS];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= STEPS + 3; s++) r_v[s] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= STEPS + 3; s++) r_v[s] <= r_v[s-1];
        end
    end

    // quarter-turn reduction and cordic micro-rotations, one per stage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_x[k][0] <= gqc_pkg::GAIN_Q;
            r_y[k][0] <= '0;
            if (n_half[k] > gqc_pkg::HALF_PI_Q) begin
                r_z[k][0]   <= n_half[k] - gqc_pkg::PI_Q;
                r_neg[k][0] <= 1'b1;
            end else if (n_half[k] < -gqc_pkg::HALF_PI_Q) begin
                r_z[k][0]   <= n_half[k] + gqc_pkg::PI_Q;
                r_neg[k][0] <= 1'b1;
            end else begin
                r_z[k][0]   <= n_half[k];
                r_neg[k][0] <= 1'b0;
            end
            for (int s = 0; s < STEPS; s++) begin
                r_neg[k][s+1] <= r_neg[k][s];
                if (r_z[k][s] >= 0) begin
                    r_x[k][s+1] <= r_x[k][s] - (r_y[k][s] >>> s);
                    r_y[k][s+1] <= r_y[k][s] + (r_x[k][s] >>> s);
                    r_z[k][s+1] <= r_z[k][s] - gqc_pkg::atan_q(s);
                end else begin
                    r_x[k][s+1] <= r_x[k][s] + (r_y[k][s] >>> s);
                    r_y[k][s+1] <= r_y[k][s] - (r_x[k][s] >>> s);
                    r_z[k][s+1] <= r_z[k][s] + gqc_pkg::atan_q(s);
                end
            end
        end
    end

    // yaw and pitch cross products
    always_ff @(posedge i_clk) begin
        r_cycp <= gqc_pkg::mulq(w_c[2], w_c[1]);
        r_sysp <= gqc_pkg::mulq(w_s[2], w_s[1]);
        r_sycp <= gqc_pkg::mulq(w_s[2], w_c[1]);
        r_cysp <= gqc_pkg::mulq(w_c[2], w_s[1]);
        r_sr   <= w_s[0];
        r_cr   <= w_c[0];
    end

    // products with roll terms
    always_ff @(posedge i_clk) begin
        r_p0 <= gqc_pkg::mulq(r_cycp, r_cr);
        r_p1 <= gqc_pkg::mulq(r_sysp, r_sr);
        r_p2 <= gqc_pkg::mulq(r_cycp, r_sr);
        r_p3 <= gqc_pkg::mulq(r_sysp, r_cr);
        r_p4 <= gqc_pkg::mulq(r_sycp, r_sr);
        r_p5 <= gqc_pkg::mulq(r_cysp, r_cr);
        r_p6 <= gqc_pkg::mulq(r_sycp, r_cr);
        r_p7 <= gqc_pkg::mulq(r_cysp, r_sr);
    end

    // quaternion components
    always_ff @(posedge i_clk) begin
        o_a <= r_p0 + r_p1;
        o_b <= r_p2 - r_p3;
        o_c <= r_p4 + r_p5;
        o_d <= r_p6 - r_p7;
    end

    assign o_valid = r_v[STEPS+3];

endmodule

### design/gqc_map.sv
// transpose rotation of a vector by a quaternion, four pipeline stages
module gqc_map (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  gqc_pkg::t_q   i_a,
    input  gqc_pkg::t_q   i_b,
    input  gqc_pkg::t_q   i_c,
    input  gqc_pkg::t_q   i_d,
    input  gqc_pkg::t_q   i_vx,
    input  gqc_pkg::t_q   i_vy,
    input  gqc_pkg::t_q   i_vz,
    output logic          o_valid,
    output gqc_pkg::t_q   o_x,
    output gqc_pkg::t_q   o_y,
    output gqc_pkg::t_q   o_z
);

    logic [gqc_pkg::MAP_LAT-1:0] r_v;
    gqc_pkg::t_q r_aa, r_bb, r_cc, r_dd, r_ab, r_ac, r_ad, r_bc, r_bd, r_cd;
    gqc_pkg::t_q r_vx1, r_vy1, r_vz1, r_vx2, r_vy2, r_vz2;
    gqc_pkg::t_q r_m [0:8];
    gqc_pkg::t_q r_t [0:8];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[gqc_pkg::MAP_LAT-2:0], i_valid};
        end
    end

    // component products
    always_ff @(posedge i_clk) begin
        r_aa  <= gqc_pkg::mulq(i_a, i_a);
        r_bb  <= gqc_pkg::mulq(i_b, i_b);
        r_cc  <= gqc_pkg::mulq(i_c, i_c);
        r_dd  <= gqc_pkg::mulq(i_d, i_d);
        r_ab  <= gqc_pkg::mulq(i_a, i_b);
        r_ac  <= gqc_pkg::mulq(i_a, i_c);
        r_ad  <= gqc_pkg::mulq(i_a, i_d);
        r_bc  <= gqc_pkg::mulq(i_b, i_c);
        r_bd  <= gqc_pkg::mulq(i_b, i_d);
        r_cd  <= gqc_pkg::mulq(i_c, i_d);
        r_vx1 <= i_vx;
        r_vy1 <= i_vy;
        r_vz1 <= i_vz;
    end

    // matrix entries, row by row: y, z, x terms of X; z, x, y of Y; x, y, z of Z
    always_ff @(posedge i_clk) begin
        r_m[0] <= (r_ad + r_bc) <<< 1;
        r_m[1] <= (r_ac - r_bd) <<< 1;
        r_m[2] <= r_aa + r_bb - r_cc - r_dd;
        r_m[3] <= (r_ab + r_cd) <<< 1;
        r_m[4] <= (r_ad - r_bc) <<< 1;
        r_m[5] <= r_aa - r_bb + r_cc - r_dd;
        r_m[6] <= (r_ac + r_bd) <<< 1;
        r_m[7] <= (r_ab - r_cd) <<< 1;
        r_m[8] <= r_aa - r_bb - r_cc + r_dd;
        r_vx2  <= r_vx1;
        r_vy2  <= r_vy1;
        r_vz2  <= r_vz1;
    end

    // vector times entries
    always_ff @(posedge i_clk) begin
        r_t[0] <= gqc_pkg::mulq(r_vy2, r_m[0]);
        r_t[1] <= gqc_pkg::mulq(r_vz2, r_m[1]);
        r_t[2] <= gqc_pkg::mulq(r_vx2, r_m[2]);
        r_t[3] <= gqc_pkg::mulq(r_vz2, r_m[3]);
        r_t[4] <= gqc_pkg::mulq(r_vx2, r_m[4]);
        r_t[5] <= gqc_pkg::mulq(r_vy2, r_m[5]);
        r_t[6] <= gqc_pkg::mulq(r_vx2, r_m[6]);
        r_t[7] <= gqc_pkg::mulq(r_vy2, r_m[7]);
        r_t[8] <= gqc_pkg::mulq(r_vz2, r_m[8]);
    end

    // row sums
    always_ff @(posedge i_clk) begin
        o_x <= r_t[0] - r_t[1] + r_t[2];
        o_y <= r_t[3] - r_t[4] + r_t[5];
        o_z <= r_t[6] - r_t[7] + r_t[8];
    end

    assign o_valid = r_v[gqc_pkg::MAP_LAT-1];

endmodule

### design/gimbal_quaternion_compensation_top.sv
// top level of the gimbal drive compensation block
// A fully pipelined block that takes one item in every cycle and never stalls: busy is
// always low. Each item's result appears on o_comp_x/y/z with o_valid high for one cycle,
// once it has passed through the two quaternion builders, each three parallel CORDIC
// pipelines of one micro-rotation per stage, plus two four-stage vector rotations and the
// output register.
module gimbal_quaternion_compensation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [gqc_pkg::ANGLE_WIDTH-1:0] i_chassis_roll,
    input  logic signed [gqc_pkg::ANGLE_WIDTH-1:0] i_chassis_pitch,
    input  logic signed [gqc_pkg::ANGLE_WIDTH-1:0] i_gimbal_roll,
    input  logic signed [gqc_pkg::ANGLE_WIDTH-1:0] i_gimbal_pitch,
    input  logic signed [gqc_pkg::ANGLE_WIDTH-1:0] i_gimbal_yaw,
    input  logic signed [gqc_pkg::VALUE_WIDTH-1:0] i_drive_x,
    input  logic signed [gqc_pkg::VALUE_WIDTH-1:0] i_drive_y,
    input  logic signed [gqc_pkg::VALUE_WIDTH-1:0] i_drive_z,
    output logic        o_valid,
    output logic signed [gqc_pkg::VALUE_WIDTH-1:0] o_comp_x,
    output logic signed [gqc_pkg::VALUE_WIDTH-1:0] o_comp_y,
    output logic signed [gqc_pkg::VALUE_WIDTH-1:0] o_comp_z
);

    localparam int EL = gqc_pkg::EULER_LAT;
    localparam int DL = gqc_pkg::DRV_LAT;
    localparam gqc_pkg::t_q SAT_HI = gqc_pkg::t_q'((64'sd1 <<< (gqc_pkg::VALUE_WIDTH-1)) - 1);
    localparam gqc_pkg::t_q SAT_LO = -SAT_HI - gqc_pkg::t_q'(1);

    logic        w_in_valid;
    gqc_pkg::t_q w_cr, w_cp, w_gr, w_gp, w_gy;
    gqc_pkg::t_q r_chas [0:EL-1][0:1];
    gqc_pkg::t_q r_drv  [0:DL-1][0:2];

    logic        w_e1_valid, w_m1_valid, w_e2_valid, w_m2_valid;
    gqc_pkg::t_q w_qa, w_qb, w_qc, w_qd;
    gqc_pkg::t_q w_rx, w_ry, w_rz;
    gqc_pkg::t_q w_ra, w_rb, w_rc, w_rd;
    gqc_pkg::t_q w_ox, w_oy, w_oz;

    assign busy       = 1'b0;
    assign w_in_valid = start & ~busy;

    // angles to q.30
    assign w_cr = gqc_pkg::t_q'(i_chassis_roll)  <<< gqc_pkg::ANG_SHIFT;
    assign w_cp = gqc_pkg::t_q'(i_chassis_pitch) <<< gqc_pkg::ANG_SHIFT;
    assign w_gr = gqc_pkg::t_q'(i_gimbal_roll)   <<< gqc_pkg::ANG_SHIFT;
    assign w_gp = gqc_pkg::t_q'(i_gimbal_pitch)  <<< gqc_pkg::ANG_SHIFT;
    assign w_gy = gqc_pkg::t_q'(i_gimbal_yaw)    <<< gqc_pkg::ANG_SHIFT;

    // delay lines aligning chassis angles and drive values with the quaternions
    always_ff @(posedge i_clk) begin
        r_chas[0][0] <= w_cr;
        r_chas[0][1] <= w_cp;
        for (int i = 1; i < EL; i++) begin
            r_chas[i][0] <= r_chas[i-1][0];
            r_chas[i][1] <= r_chas[i-1][1];
        end
        r_drv[0][0] <= gqc_pkg::t_q'(i_drive_x);
        r_drv[0][1] <= gqc_pkg::t_q'(i_drive_y);
        r_drv[0][2] <= gqc_pkg::t_q'(i_drive_z);
        for (int i = 1; i < DL; i++) begin
            r_drv[i][0] <= r_drv[i-1][0];
            r_drv[i][1] <= r_drv[i-1][1];
            r_drv[i][2] <= r_drv[i-1][2];
        end
    end

    // motor quaternion
    gqc_euler u_euler_motor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_valid),
        .i_roll  (w_gr),
        .i_pitch (w_gp),
        .i_yaw   (w_gy),
        .o_valid (w_e1_valid),
        .o_a     (w_qa),
        .o_b     (w_qb),
        .o_c     (w_qc),
        .o_d     (w_qd)
    );

    // chassis attitude in the gimbal frame
    gqc_map u_map_chassis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_e1_valid),
        .i_a     (w_qa),
        .i_b     (w_qb),
        .i_c     (w_qc),
        .i_d     (w_qd),
        .i_vx    (r_chas[EL-1][0]),
        .i_vy    (r_chas[EL-1][1]),
        .i_vz    ('0),
        .o_valid (w_m1_valid),
        .o_x     (w_rx),
        .o_y     (w_ry),
        .o_z     (w_rz)
    );

    // relative quaternion
    gqc_euler u_euler_rel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_m1_valid),
        .i_roll  (w_rx),
        .i_pitch (w_ry),
        .i_yaw   (w_rz),
        .o_valid (w_e2_valid),
        .o_a     (w_ra),
        .o_b     (w_rb),
        .o_c     (w_rc),
        .o_d     (w_rd)
    );

    // drive vector mapping
    gqc_map u_map_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_e2_valid),
        .i_a     (w_ra),
        .i_b     (w_rb),
        .i_c     (w_rc),
        .i_d     (w_rd),
        .i_vx    (r_drv[DL-1][0]),
        .i_vy    (r_drv[DL-1][1]),
        .i_vz    (r_drv[DL-1][2]),
        .o_valid (w_m2_valid),
        .o_x     (w_ox),
        .o_y     (w_oy),
        .o_z     (w_oz)
    );

    // clamp to the output range
    function automatic logic signed [gqc_pkg::VALUE_WIDTH-1:0] sat(input gqc_pkg::t_q v);
        gqc_pkg::t_q t;
        t = v;
        if (v > SAT_HI) t = SAT_HI;
        if (v < SAT_LO) t = SAT_LO;
        return t[gqc_pkg::VALUE_WIDTH-1:0];
    endfunction

    // output register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_m2_valid;
        end
        o_comp_x <= sat(w_ox);
        o_comp_y <= sat(w_oy);
        o_comp_z <= sat(w_oz);
    end

endmodule
